/* sv/exception_entry_stacker_macros.svh */
// Assertion macros for the exception entry stacker checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef EXCEPTION_ENTRY_STACKER_MACROS_SVH
`define EXCEPTION_ENTRY_STACKER_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define EES_CHECK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("exception entry stacker check failed");

// Next-cycle implication.
`define EES_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("exception entry stacker check failed");

`endif

/* sv/ees_pkg.sv */
// Shared types, codes and constants for the exception entry stacker.
// No dependencies; the other files of the block, but for the macro header, refer to it by scoped names.
package ees_pkg;

    localparam int unsigned EXC_W      = 9;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned SIZE_W     = 3;
    localparam int unsigned FLAG_W     = 4;
    localparam int unsigned SEL_W      = 3;
    localparam int unsigned BEAT_W     = 4;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [EXC_W-1:0] EXC_HARDFAULT = 9'd3;
    localparam logic [EXC_W-1:0] EXC_SVCALL    = 9'd11;
    localparam logic [EXC_W-1:0] EXC_PENDSV    = 9'd14;
    localparam logic [EXC_W-1:0] EXC_SYSTICK   = 9'd15;
    localparam logic [EXC_W-1:0] EXC_IRQ0      = 9'd16;

    localparam logic [WORD_W-1:0] EXC_RET_HANDLER = 32'hFFFF_FFF1;
    localparam logic [WORD_W-1:0] EXC_RET_PSP     = 32'hFFFF_FFFD;
    localparam logic [WORD_W-1:0] EXC_RET_MSP     = 32'hFFFF_FFF9;
    localparam logic [WORD_W-1:0] FRAME_BYTES     = 32'h0000_0020;

    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STACK_ALIGN = 1'd1;

    localparam logic [SEL_W-1:0] SEL_LR   = 3'd5;
    localparam logic [SEL_W-1:0] SEL_WORD = 3'd6;

    localparam logic [BEAT_W-1:0] BEAT_RET  = 4'd6;
    localparam logic [BEAT_W-1:0] BEAT_PSR  = 4'd7;
    localparam logic [BEAT_W-1:0] BEAT_DONE = 4'd8;

    typedef enum logic [1:0] {
        KIND_STACK    = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_LOCKUP   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [EXC_W-1:0]  exc_number;
        logic              activate_ok;
        logic              hardfault_ok;
        logic [WORD_W-1:0] current_pc;
        logic              thumb_state;
        logic [SIZE_W-1:0] inst_size;
        logic [WORD_W-1:0] stack_pointer;
        logic [WORD_W-1:0] main_sp;
        logic [WORD_W-1:0] status_word;
        logic [FLAG_W-1:0] live_nzcv;
        logic [FLAG_W-1:0] live_ge;
        logic              stack_select;
    } req_t;

    typedef struct packed {
        logic [1:0]        result_kind;
        logic [WORD_W-1:0] write_addr;
        logic [SEL_W-1:0]  data_select;
        logic [WORD_W-1:0] data_word;
        logic [EXC_W-1:0]  taken_exc;
        logic [WORD_W-1:0] frame_sp;
        logic              frame_to_psp;
        logic [WORD_W-1:0] next_r13;
        logic [WORD_W-1:0] entry_lr;
        logic [WORD_W-1:0] vector_addr;
        logic [WORD_W-1:0] next_status;
        logic              last;
    } res_t;

    typedef struct packed {
        logic [WORD_W-1:0] vector_base;
        logic              stack_align;
    } cfg_t;

    typedef struct packed {
        logic              lockup;
        logic [EXC_W-1:0]  taken;
        logic [WORD_W-1:0] frame;
        logic [WORD_W-1:0] ret_addr;
        logic [WORD_W-1:0] stacked_psr;
        logic              to_psp;
        logic [WORD_W-1:0] next_r13;
        logic [WORD_W-1:0] entry_lr;
        logic [WORD_W-1:0] vector_addr;
        logic [WORD_W-1:0] next_status;
    } ctx_t;

endpackage

/* sv/ees_req_if.sv */
// Request channel of the exception entry stacker: valid, ready and payload.
// Depends on ees_pkg for the payload type.
interface ees_req_if;
    logic          valid;
    logic          ready;
    ees_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/ees_res_if.sv */
// Result channel of the exception entry stacker: valid, ready and payload.
// Depends on ees_pkg for the payload type.
interface ees_res_if;
    logic          valid;
    logic          ready;
    ees_pkg::res_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/exception_entry_stacker.sv */
// Exception entry stacker top level: configuration registers, request
// register, decode and frame sequencer. Depends on ees_pkg, ees_req_if,
// ees_res_if, ees_decode and ees_sequencer.
//
//   channel   dir   payload                      handshake
//   req       in    ees_pkg::req_t               valid/ready
//   res       out   ees_pkg::res_t               valid/ready
//   cfg       in    cfg_index, cfg_wdata         cfg_we, no stall
//
// A request gives nine results (one for a lockup), one per cycle while the
// result channel does not stall, paced by the sequencer's beat counter.
// The first result passes the request, context and result registers after
// acceptance. The next request is taken while the current one runs.
// A stalled result holds in the result register and stops the beat counter.
// Reset clears the valid flags and sets vector_base 0, stack_align 1.
module exception_entry_stacker (
    input  logic                           clk,
    input  logic                           rst_n,
    ees_req_if.sink                        req,
    ees_res_if.source                      res,
    input  logic                           cfg_we,
    input  logic [ees_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ees_pkg::WORD_W-1:0]     cfg_wdata
);

    ees_pkg::cfg_t cfg_reg;
    ees_pkg::cfg_t cfg_next;
    logic          in_valid_reg;
    logic          in_valid_next;
    ees_pkg::req_t in_reg;
    ees_pkg::ctx_t ctx;
    logic          ctx_take;
    logic          accept;

    assign req.ready = !in_valid_reg || ctx_take;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ees_pkg::REG_VECTOR_BASE: cfg_next.vector_base = cfg_wdata;
                ees_pkg::REG_STACK_ALIGN: cfg_next.stack_align = cfg_wdata[0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (ctx_take)
        begin
            in_valid_next = 1'b0;
        end
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vector_base <= '0;
            cfg_reg.stack_align <= 1'b1;
            in_valid_reg        <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= req.data;
        end
    end

    ees_decode u_decode (
        .req (in_reg),
        .cfg (cfg_reg),
        .ctx (ctx)
    );

    ees_sequencer u_sequencer (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctx_valid_in (in_valid_reg),
        .ctx_in       (ctx),
        .ctx_take     (ctx_take),
        .res_valid    (res.valid),
        .res_ready    (res.ready),
        .res_data     (res.data)
    );

endmodule

/* sv/ees_decode.sv */
// Request decode: escalation, frame address, stacked and new status words,
// LR return code and vector address, all from one registered request.
// Depends on ees_pkg.
module ees_decode (
    input  ees_pkg::req_t req,
    input  ees_pkg::cfg_t cfg,
    output ees_pkg::ctx_t ctx
);

    logic                      is_async;
    logic                      blocked;
    logic [ees_pkg::EXC_W-1:0] taken;
    logic                      in_handler;
    logic                      use_psp;
    logic                      pad;
    logic [ees_pkg::WORD_W-1:0] synced;
    logic [ees_pkg::WORD_W-1:0] frame;

    always_comb
    begin
        is_async = (req.exc_number >= ees_pkg::EXC_IRQ0)
                   || (req.exc_number == ees_pkg::EXC_PENDSV)
                   || (req.exc_number == ees_pkg::EXC_SYSTICK);
        blocked  = !req.activate_ok && !is_async;
        taken    = blocked ? ees_pkg::EXC_HARDFAULT : req.exc_number;

        in_handler = (req.status_word[8:0] != '0);
        use_psp    = !in_handler && req.stack_select;
        pad        = cfg.stack_align && req.stack_pointer[2];

        synced          = req.status_word;
        synced[31:28]   = req.live_nzcv;
        synced[19:16]   = req.live_ge;

        frame = req.stack_pointer - ees_pkg::FRAME_BYTES;
        if (cfg.stack_align)
        begin
            frame[2] = 1'b0;
        end

        ctx        = '0;
        ctx.lockup = blocked && ((req.exc_number == ees_pkg::EXC_HARDFAULT)
                                 || !req.hardfault_ok);
        ctx.taken  = taken;
        ctx.frame  = frame;

        if (taken == ees_pkg::EXC_SVCALL)
        begin
            ctx.ret_addr = req.current_pc
                           + {{(ees_pkg::WORD_W-ees_pkg::SIZE_W){1'b0}}, req.inst_size};
        end
        else
        begin
            ctx.ret_addr = req.current_pc;
        end

        ctx.stacked_psr     = synced;
        ctx.stacked_psr[24] = req.thumb_state;
        ctx.stacked_psr[9]  = pad;

        ctx.to_psp   = use_psp;
        ctx.next_r13 = use_psp ? req.main_sp : frame;

        if (in_handler)
        begin
            ctx.entry_lr = ees_pkg::EXC_RET_HANDLER;
        end
        else if (use_psp)
        begin
            ctx.entry_lr = ees_pkg::EXC_RET_PSP;
        end
        else
        begin
            ctx.entry_lr = ees_pkg::EXC_RET_MSP;
        end

        ctx.vector_addr = cfg.vector_base
                          + {{(ees_pkg::WORD_W-ees_pkg::EXC_W-2){1'b0}}, taken, 2'b00};

        ctx.next_status        = synced;
        ctx.next_status[26:25] = 2'b00;
        ctx.next_status[15:10] = 6'b0;
        ctx.next_status[8:0]   = taken;
    end

endmodule

/* sv/ees_sequencer.sv */
// Frame sequencer: holds one decoded request, steps a beat counter through
// the eight frame writes and the completion, or gives a single lockup result, and drives the result register.
// Depends on ees_pkg.
module ees_sequencer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          ctx_valid_in,
    input  ees_pkg::ctx_t ctx_in,
    output logic          ctx_take,
    output logic          res_valid,
    input  logic          res_ready,
    output ees_pkg::res_t res_data
);

    logic                       ctx_valid_reg;
    logic                       ctx_valid_next;
    ees_pkg::ctx_t              ctx_reg;
    logic [ees_pkg::BEAT_W-1:0] beat_reg;
    logic [ees_pkg::BEAT_W-1:0] beat_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    ees_pkg::res_t              out_reg;
    ees_pkg::res_t              beat_res;
    logic                       advance;
    logic                       load;

    assign advance  = ctx_valid_reg && (!out_valid_reg || res_ready);
    assign ctx_take = !ctx_valid_reg || (advance && beat_res.last);
    assign load     = ctx_valid_in && ctx_take;

    always_comb
    begin
        beat_res = '0;
        if (ctx_reg.lockup)
        begin
            beat_res.result_kind = ees_pkg::KIND_LOCKUP;
            beat_res.taken_exc   = ees_pkg::EXC_HARDFAULT;
            beat_res.last        = 1'b1;
        end
        else if (beat_reg == ees_pkg::BEAT_DONE)
        begin
            beat_res.result_kind  = ees_pkg::KIND_COMPLETE;
            beat_res.taken_exc    = ctx_reg.taken;
            beat_res.frame_sp     = ctx_reg.frame;
            beat_res.frame_to_psp = ctx_reg.to_psp;
            beat_res.next_r13     = ctx_reg.next_r13;
            beat_res.entry_lr     = ctx_reg.entry_lr;
            beat_res.vector_addr  = ctx_reg.vector_addr;
            beat_res.next_status  = ctx_reg.next_status;
            beat_res.last         = 1'b1;
        end
        else
        begin
            beat_res.result_kind = ees_pkg::KIND_STACK;
            beat_res.write_addr  = ctx_reg.frame
                                   + {{(ees_pkg::WORD_W-5){1'b0}}, beat_reg[2:0], 2'b00};
            if (beat_reg < ees_pkg::BEAT_RET)
            begin
                beat_res.data_select = beat_reg[ees_pkg::SEL_W-1:0];
            end
            else
            begin
                beat_res.data_select = ees_pkg::SEL_WORD;
                beat_res.data_word   = (beat_reg == ees_pkg::BEAT_RET)
                                       ? ctx_reg.ret_addr : ctx_reg.stacked_psr;
            end
        end
    end

    always_comb
    begin
        ctx_valid_next = ctx_valid_reg;
        beat_next      = beat_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            beat_next      = beat_reg + {{(ees_pkg::BEAT_W-1){1'b0}}, 1'b1};
            if (beat_res.last)
            begin
                ctx_valid_next = 1'b0;
            end
        end
        if (load)
        begin
            ctx_valid_next = 1'b1;
            beat_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_valid_reg <= 1'b0;
            beat_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ctx_valid_reg <= ctx_valid_next;
            beat_reg      <= beat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctx_reg <= ctx_in;
        end
        if (advance)
        begin
            out_reg <= beat_res;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

endmodule

/* sv/ees_checker.sv */
// Port-level checks on the exception entry stacker result channel.
// Depends on ees_pkg and exception_entry_stacker_macros.svh; bound to the top.
`include "exception_entry_stacker_macros.svh"

module ees_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          res_valid,
    input logic          res_ready,
    input ees_pkg::res_t res_data
);

    `EES_CHECK_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data))
    `EES_CHECK_NOW(a_lockup_single, res_valid && res_data.result_kind == ees_pkg::KIND_LOCKUP, res_data.last && res_data.taken_exc == ees_pkg::EXC_HARDFAULT)
    `EES_CHECK_NOW(a_write_not_last, res_valid && res_data.result_kind == ees_pkg::KIND_STACK, !res_data.last)
    `EES_CHECK_NOW(a_ipsr_taken, res_valid && res_data.result_kind == ees_pkg::KIND_COMPLETE, res_data.next_status[8:0] == res_data.taken_exc && res_data.last)

endmodule

bind exception_entry_stacker ees_checker u_ees_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
);
